[hw/rtl/rtad_pkg.sv]
package rtad_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;

  localparam int BASE_MIN      = 2;
  localparam int BASE_MAX      = 36;
  localparam int BASE_RESET    = 10;
  localparam int DECIMAL_LIMIT = 10;
  localparam int LETTER_OFFSET = 55;
  localparam int ASCII_ZERO    = 48;

  localparam int QUEUE_DEPTH = 2;

  // digit 0..35 to '0'..'9','A'..'Z'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(DECIMAL_LIMIT)) begin
      c = CHAR_W'(ASCII_ZERO) + CHAR_W'(d);
    end else begin
      c = CHAR_W'(LETTER_OFFSET) + CHAR_W'(d);
    end
    return c;
  endfunction

  function automatic logic [DIGIT_W-1:0] clamp_base(input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W-1:0] r;
    if (b < DIGIT_W'(BASE_MIN)) begin
      r = DIGIT_W'(BASE_MIN);
    end else if (b > DIGIT_W'(BASE_MAX)) begin
      r = DIGIT_W'(BASE_MAX);
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

[hw/rtl/rtad_front.sv]
module rtad_front
  import rtad_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   q_push,
  input  logic                   q_full,
  output logic [VALUE_WIDTH:0]   q_data
);

  logic                   slot_valid;
  logic [VALUE_WIDTH-1:0] slot_value;
  logic                   slot_zero;
  logic                   accept;
  logic                   drain;

  assign drain  = slot_valid && !q_full;
  assign full   = slot_valid && q_full;
  assign accept = push && !full;
  assign q_push = drain;
  assign q_data = {slot_zero, slot_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (accept) begin
      slot_valid <= 1'b1;
    end else if (drain) begin
      slot_valid <= 1'b0;
    end
  end

  // tag zero inputs so the back end skips the divider
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_value <= value;
      slot_zero  <= (value == '0);
    end
  end

endmodule

[hw/rtl/rtad_queue.sv]
module rtad_queue
  import rtad_pkg::*;
#(
  parameter int WIDTH = VALUE_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

[hw/rtl/rtad_back.sv]
module rtad_back
  import rtad_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [DIGIT_W-1:0]     base,
  input  logic                   q_empty,
  input  logic [VALUE_WIDTH:0]   q_data,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAR_W-1:0]      ascii_char,
  output logic                   last_char
);

  localparam int SW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state;
  logic [VALUE_WIDTH-1:0] quot;
  logic [DIGIT_W-1:0]     rem;
  logic [SW-1:0]          bit_cnt;
  logic [CW-1:0]          digit_count;
  logic [SW-1:0]          idx;
  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;

  logic [DIGIT_W-1:0]     digit_stack [VALUE_WIDTH];
  logic [DIGIT_W-1:0]     stack_rd;
  logic                   stack_we;
  logic [SW-1:0]          stack_wa;
  logic [DIGIT_W-1:0]     stack_wd;

  logic [DIGIT_W:0]       rem_shift;
  logic                   ge;
  logic [DIGIT_W-1:0]     rem_next;
  logic [VALUE_WIDTH-1:0] quot_next;
  logic                   last_bit;
  logic                   q_zero;

  // one restoring division step per cycle
  always_comb begin
    rem_shift = {rem, quot[VALUE_WIDTH-1]};
    ge        = (rem_shift >= {1'b0, base});
    rem_next  = ge ? DIGIT_W'(rem_shift - {1'b0, base}) : rem_shift[DIGIT_W-1:0];
    quot_next = {quot[VALUE_WIDTH-2:0], ge};
  end

  assign last_bit = (bit_cnt == SW'(VALUE_WIDTH - 1));
  assign q_zero   = q_data[VALUE_WIDTH];
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    stack_we = 1'b0;
    stack_wa = digit_count[SW-1:0];
    stack_wd = rem_next;
    if (state == S_IDLE && !q_empty && q_zero) begin
      stack_we = 1'b1;
      stack_wa = '0;
      stack_wd = '0;
    end else if (state == S_DIV && last_bit) begin
      stack_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      digit_stack[stack_wa] <= stack_wd;
    end
    stack_rd <= digit_stack[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      digit_count <= '0;
      quot        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_zero) begin
              digit_count <= CW'(1);
              idx         <= '0;
              state       <= S_RD;
            end else begin
              quot        <= q_data[VALUE_WIDTH-1:0];
              rem         <= '0;
              bit_cnt     <= '0;
              digit_count <= '0;
              state       <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quot    <= quot_next;
          rem     <= rem_next;
          bit_cnt <= bit_cnt + 1'b1;
          if (last_bit) begin
            digit_count <= digit_count + 1'b1;
            rem         <= '0;
            bit_cnt     <= '0;
            if (quot_next == '0) begin
              idx   <= digit_count[SW-1:0];
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          out_char  <= digit_to_ascii(stack_rd);
          out_last  <= (idx == '0);
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (pop) begin
            out_valid <= 1'b0;
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty      = !out_valid;
  assign ascii_char = out_char;
  assign last_char  = out_last;

endmodule

[hw/rtl/radix_to_ascii_digits_top.sv]
// a nonzero value is turned into digits by a serial divider (one divider step per cycle,
// VALUE_WIDTH steps per digit); a zero value skips the divider
// one item at a time in the back end: its chars all leave before the next item is taken;
// up to three more items wait in front
// reset: rst is synchronous, active high; base returns to 10, all queues empty
module radix_to_ascii_digits_top
  import rtad_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value,
  // result items
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAR_W-1:0]      ascii_char,
  output logic                   last_char,
  // base register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [DIGIT_W-1:0]     cfg_data
);

  logic                 q_push;
  logic                 q_full;
  logic [VALUE_WIDTH:0] q_wdata;
  logic                 q_pop;
  logic                 q_empty;
  logic [VALUE_WIDTH:0] q_rdata;
  logic [DIGIT_W-1:0]   base;

  // base register, writes clamped to 2..36
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= DIGIT_W'(BASE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      base <= clamp_base(cfg_data);
    end
  end

  // front: takes items, tags zero values
  rtad_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .value  (value),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  // short queue of tagged items between front and back
  rtad_queue #(
    .WIDTH(VALUE_WIDTH + 1)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rdata)
  );

  // back: serial divider, digit stack, char output register
  rtad_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .base       (base),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule

[verif/tb_radix_to_ascii_digits_top.sv]
module tb_radix_to_ascii_digits_top;
  import rtad_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  // cycles left after the last char before the block counts as quiet
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 100;

  // one expected output char
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [VW-1:0]     value = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [CHAR_W-1:0] ascii_char;
  logic              last_char;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DIGIT_W-1:0] cfg_data = '0;

  // values waiting to be offered, and chars still owed by the block
  logic [VW-1:0] send_queue [$];
  char_item_t    char_queue [$];

  // shadow of the block's base register
  logic [DIGIT_W-1:0] radix_shadow = DIGIT_W'(BASE_RESET);

  // idle percentages for the sender and the receiver
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned send_gap = 0;
  int unsigned pop_stall = 0;

  int unsigned values_accepted = 0;
  int unsigned chars_checked = 0;
  int unsigned radix_writes = 0;
  int unsigned err_cnt = 0;

  radix_to_ascii_digits_top DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .empty     (empty),
    .pop       (pop),
    .ascii_char(ascii_char),
    .last_char (last_char),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short idles, now and then a long one
  function automatic int unsigned pick_idle(input int unsigned pct);
    if ($urandom_range(99, 0) < pct) begin
      if ($urandom_range(9, 0) == 0) begin
        return $urandom_range(40, 15);
      end
      return $urandom_range(3, 1);
    end
    return 0;
  endfunction

  // repeated division by the radix, remainders stacked, then popped
  // msd first; each digit maps to '0'..'9' or 'A'..'Z'
  function automatic void predict_chars(input logic [VW-1:0] v);
    logic [DIGIT_W-1:0] digits [VW];
    logic [DIGIT_W-1:0] d;
    logic [VW-1:0]      quot;
    int unsigned        n;
    char_item_t         c;
    quot = v;
    n = 0;
    do begin
      if (n < VW) begin
        digits[n] = DIGIT_W'(quot % radix_shadow);
        n++;
      end
      quot = quot / radix_shadow;
    end while (quot != 0);
    for (int unsigned k = 0; k < n; k++) begin
      d = digits[n - 1 - k];
      if (d < DECIMAL_LIMIT) begin
        c.code = CHAR_W'(ASCII_ZERO) + CHAR_W'(d);
      end else begin
        c.code = CHAR_W'(LETTER_OFFSET) + CHAR_W'(d);
      end
      c.last = (k + 1 == n);
      char_queue.push_back(c);
    end
  endfunction

  // sender: offers queued values, predicts chars as each item is taken
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_chars(value);
        void'(send_queue.pop_front());
        values_accepted++;
        send_gap = pick_idle(gap_pct);
      end
      // an offer that was not taken stays on the bus unchanged
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (send_queue.size() != 0) begin
          push  <= 1'b1;
          value <= send_queue[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: random pop stalls, each taken char checked against the oldest prediction
  always @(posedge clk) begin : check_chars
    char_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (char_queue.size() == 0) begin
          $error("unexpected char: ascii_char %0d last_char %0d", ascii_char, last_char);
          err_cnt++;
        end else begin
          want = char_queue.pop_front();
          if (ascii_char !== want.code) begin
            $error("ascii_char mismatch: expected %0d, actual %0d", want.code, ascii_char);
            err_cnt++;
          end
          if (last_char !== want.last) begin
            $error("last_char mismatch: expected %0d, actual %0d", want.last, last_char);
            err_cnt++;
          end
          chars_checked++;
        end
      end
      if (pop_stall != 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_stall = pick_idle(stall_pct);
      end
    end
  end

  task automatic send_item(input logic [VW-1:0] v);
    send_queue.push_back(v);
  endtask

  // everything offered, taken and checked, then the settle wait
  task automatic wait_idle();
    while (send_queue.size() != 0 || push || char_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // base register write, only with the block quiet
  task automatic write_radix(input logic [DIGIT_W-1:0] d);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // out-of-range writes saturate at the legal ends
    if (d < BASE_MIN) begin
      radix_shadow = DIGIT_W'(BASE_MIN);
    end else if (d > BASE_MAX) begin
      radix_shadow = DIGIT_W'(BASE_MAX);
    end else begin
      radix_shadow = d;
    end
    radix_writes++;
  endtask

  // decimal out of reset, zero gives a lone '0'
  task automatic test_default_radix();
    gap_pct   = 20;
    stall_pct = 20;
    send_item(32'd0);
    send_item(32'd9);
    send_item(32'd10);
    send_item(32'hFFFF_FFFF);
    send_item(32'd1234567890);
  endtask

  // writes below 2 land on binary, incl. a full 32-digit run
  task automatic test_low_clamp();
    write_radix(6'd0);
    send_item(32'd0);
    send_item(32'd1);
    send_item(32'h8000_0000);
    send_item(32'h5555_5555);
    write_radix(6'd1);
    send_item(32'd2);
  endtask

  // writes above 36 land on 36, letters up to 'Z'
  task automatic test_high_clamp();
    write_radix(6'd63);
    send_item(32'd35);
    send_item(32'd36);
    send_item(32'hFFFF_FFFF);
    send_item(32'd1295);
    write_radix(6'd37);
    send_item(32'd1296);
  endtask

  // legal edges and a couple of common radixes
  task automatic test_legal_radixes();
    write_radix(6'd2);
    send_item(32'hFFFF_FFFF);
    write_radix(6'd36);
    send_item(32'd10);
    write_radix(6'd16);
    send_item(32'hDEAD_BEEF);
    send_item(32'h0000_000F);
    write_radix(6'd8);
    send_item(32'h1234_5678);
  endtask

  // phases of random radix and random idling, values of mixed shape
  task automatic test_random_values();
    logic [DIGIT_W-1:0] pick;
    logic [VW-1:0]      v;
    int unsigned        ph;
    int unsigned        j;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: pick = 6'd10;
        1: pick = 6'd2;
        default: pick = DIGIT_W'($urandom_range(63, 0));
      endcase
      write_radix(pick);
      // first phase runs back to back with no idling at all
      if (ph == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(60, 5);
        stall_pct = $urandom_range(60, 5);
      end
      for (j = 0; j < 10; j++) begin
        case ($urandom_range(3, 0))
          0: v = $urandom();
          1: v = $urandom_range(99, 0);
          2: v = 32'hFFFF_FFFF - $urandom_range(3, 0);
          default: begin
            // powers of the radix and one below, where digit counts roll over
            v = 1;
            repeat ($urandom_range(6, 1)) v = v * radix_shadow;
            if ($urandom_range(1, 0) == 1) begin
              v = v - 1;
            end
          end
        endcase
        send_item(v);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_radix();
    test_low_clamp();
    test_high_clamp();
    test_legal_radixes();
    test_random_values();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("converted %0d values into %0d checked chars", values_accepted, chars_checked);
    $display("base register written %0d times, clamped and legal radixes", radix_writes);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // safety net, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
